@@ rtl/core/vector_int_muldiv_alu_unit_macros.svh @@
// Assertion helpers for the RTL that checks itself.
// Each expects clk and rst in the scope where it is used.
`ifndef VECTOR_INT_MULDIV_ALU_UNIT_MACROS_SVH
`define VECTOR_INT_MULDIV_ALU_UNIT_MACROS_SVH

// Same-cycle implication
`define VIMD_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VIMD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/vimd_pkg.sv @@
package vimd_pkg;

  localparam int DATA_W    = 64;
  localparam int DIV_STEPS = 64;

  // funct6 codes
  localparam logic [5:0] F6_VAADDU   = 6'h08;
  localparam logic [5:0] F6_VAADD    = 6'h09;
  localparam logic [5:0] F6_VASUBU   = 6'h0a;
  localparam logic [5:0] F6_VASUB    = 6'h0b;
  localparam logic [5:0] F6_VDIVU    = 6'h20;
  localparam logic [5:0] F6_VDIV     = 6'h21;
  localparam logic [5:0] F6_VREMU    = 6'h22;
  localparam logic [5:0] F6_VREM     = 6'h23;
  localparam logic [5:0] F6_VMULHU   = 6'h24;
  localparam logic [5:0] F6_VMUL     = 6'h25;
  localparam logic [5:0] F6_VMULHSU  = 6'h26;
  localparam logic [5:0] F6_VMULH    = 6'h27;
  localparam logic [5:0] F6_VMADD    = 6'h29;
  localparam logic [5:0] F6_VNMSUB   = 6'h2b;
  localparam logic [5:0] F6_VMACC    = 6'h2d;
  localparam logic [5:0] F6_VNMSAC   = 6'h2f;
  localparam logic [5:0] F6_VWADDU   = 6'h30;
  localparam logic [5:0] F6_VWADD    = 6'h31;
  localparam logic [5:0] F6_VWSUBU   = 6'h32;
  localparam logic [5:0] F6_VWSUB    = 6'h33;
  localparam logic [5:0] F6_VWADDU_W = 6'h34;
  localparam logic [5:0] F6_VWADD_W  = 6'h35;
  localparam logic [5:0] F6_VWSUBU_W = 6'h36;
  localparam logic [5:0] F6_VWSUB_W  = 6'h37;
  localparam logic [5:0] F6_VWMULU   = 6'h38;
  localparam logic [5:0] F6_VWMULSU  = 6'h3a;
  localparam logic [5:0] F6_VWMUL    = 6'h3b;
  localparam logic [5:0] F6_VWMACCU  = 6'h3c;
  localparam logic [5:0] F6_VWMACC   = 6'h3d;
  localparam logic [5:0] F6_VWMACCUS = 6'h3e;
  localparam logic [5:0] F6_VWMACCSU = 6'h3f;

  // element width codes
  localparam logic [1:0] SEW_8  = 2'd0;
  localparam logic [1:0] SEW_16 = 2'd1;
  localparam logic [1:0] SEW_32 = 2'd2;
  localparam logic [1:0] SEW_64 = 2'd3;

  // fixed-point rounding modes
  localparam logic [1:0] RM_RNU = 2'd0;
  localparam logic [1:0] RM_RNE = 2'd1;
  localparam logic [1:0] RM_RDN = 2'd2;
  localparam logic [1:0] RM_ROD = 2'd3;

  // register indexes
  localparam logic CFG_SEW  = 1'b0;
  localparam logic CFG_VXRM = 1'b1;

  // unit that produces the result
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_AVG  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;
  localparam logic [1:0] KIND_DIV  = 2'd3;

  typedef struct packed {
    logic [5:0]        req_type;
    logic [DATA_W-1:0] src_a;
    logic [DATA_W-1:0] src_b;
    logic [DATA_W-1:0] acc_in;
    logic              active;
  } vimd_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              write_enable;
  } vimd_rsp_t;

  // Operation in flight. a/b/c are reused per kind:
  //   MUL: a, b factors, c addend (result after the multiplier)
  //   AVG: a, b addends; DIV: a dividend, b divisor magnitudes
  //   PASS: c result
  typedef struct packed {
    logic              we;
    logic [1:0]        kind;
    logic [1:0]        sew_code;
    logic [1:0]        out_code;
    logic [1:0]        vxrm;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic              x_neg;
    logic              y_neg;
    logic              hi_sel;
    logic              acc_sub;
    logic              avg_cin;
    logic              avg_hx;
    logic              q_neg;
    logic              r_neg;
    logic              rem_sel;
  } vimd_op_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      SEW_8:   m = 64'h0000_0000_0000_00ff;
      SEW_16:  m = 64'h0000_0000_0000_ffff;
      SEW_32:  m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] sext(input logic [DATA_W-1:0] x,
                                             input logic [1:0] code);
    logic [DATA_W-1:0] r;
    case (code)
      SEW_8:   r = {{56{x[7]}}, x[7:0]};
      SEW_16:  r = {{48{x[15]}}, x[15:0]};
      SEW_32:  r = {{32{x[31]}}, x[31:0]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/vimd_chan_if.sv @@
interface vimd_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/vimd_decode.sv @@
module vimd_decode #(
  parameter int MAX_ELEMENT_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  vimd_pkg::vimd_req_t  req_data,
  input  logic [1:0]           sew_code,
  input  logic [1:0]           vxrm,
  output logic                 out_valid,
  output vimd_pkg::vimd_op_t   op
);
  import vimd_pkg::*;

  logic [5:0]        f6;
  logic [1:0]        wcode;
  logic [6:0]        sew_bits;
  logic [7:0]        wide_bits;
  logic              sew_ok, wide_ok;
  logic [DATA_W-1:0] za, sa, zb, sb, zd, wd, wua, wsa;
  logic [DATA_W-1:0] avg_ea, avg_eb, mag_a, mag_b, wa, wb;
  logic              legal;
  vimd_op_t          d;

  assign f6        = req_data.req_type;
  assign wcode     = sew_code + 2'd1;
  assign sew_bits  = 7'd8 << sew_code;
  assign wide_bits = 8'd16 << sew_code;
  assign sew_ok    = int'(sew_bits) <= MAX_ELEMENT_BITS;
  assign wide_ok   = int'(wide_bits) <= MAX_ELEMENT_BITS;

  // operand views at SEW and at 2*SEW
  assign za  = req_data.src_a & width_mask(sew_code);
  assign sa  = sext(req_data.src_a, sew_code);
  assign zb  = req_data.src_b & width_mask(sew_code);
  assign sb  = sext(req_data.src_b, sew_code);
  assign zd  = req_data.acc_in & width_mask(sew_code);
  assign wd  = req_data.acc_in & width_mask(wcode);
  assign wua = req_data.src_a & width_mask(wcode);
  assign wsa = sext(req_data.src_a, wcode);

  // averaging and division operands; bit 0 of funct6 marks signed
  assign avg_ea = f6[0] ? sa : za;
  assign avg_eb = f6[0] ? sb : zb;
  assign mag_a  = f6[0] ? (sa[DATA_W-1] ? -sa : sa) : za;
  assign mag_b  = f6[0] ? (sb[DATA_W-1] ? -sb : sb) : zb;

  // widening add/sub operands; bit 2 selects the wide vs2 forms
  assign wa = f6[2] ? (f6[0] ? wsa : wua) : (f6[0] ? sa : za);
  assign wb = f6[0] ? sb : zb;

  // decode funct6 into the operation record
  always_comb begin
    d          = '0;
    legal      = 1'b0;
    d.sew_code = sew_code;
    d.out_code = sew_code;
    d.vxrm     = vxrm;
    d.kind     = KIND_MUL;
    case (f6)
      F6_VAADDU, F6_VAADD, F6_VASUBU, F6_VASUB: begin
        legal     = sew_ok;
        d.kind    = KIND_AVG;
        d.a       = avg_ea;
        d.b       = f6[1] ? ~avg_eb : avg_eb;
        d.avg_cin = f6[1];
        d.avg_hx  = (f6[0] & avg_ea[DATA_W-1]) ^ (f6[0] & avg_eb[DATA_W-1]) ^ f6[1];
      end
      F6_VDIVU, F6_VDIV, F6_VREMU, F6_VREM: begin
        legal     = sew_ok;
        d.kind    = KIND_DIV;
        d.a       = mag_a;
        d.b       = mag_b;
        d.q_neg   = f6[0] & (sa[DATA_W-1] ^ sb[DATA_W-1]) & (zb != '0);
        d.r_neg   = f6[0] & sa[DATA_W-1];
        d.rem_sel = f6[1];
      end
      F6_VMULHU: begin
        legal = sew_ok; d.a = za; d.b = zb; d.hi_sel = 1'b1;
      end
      F6_VMUL: begin
        legal = sew_ok; d.a = za; d.b = zb;
      end
      F6_VMULHSU: begin
        legal = sew_ok; d.a = sa; d.b = zb; d.hi_sel = 1'b1;
        d.x_neg = sa[DATA_W-1];
      end
      F6_VMULH: begin
        legal = sew_ok; d.a = sa; d.b = sb; d.hi_sel = 1'b1;
        d.x_neg = sa[DATA_W-1]; d.y_neg = sb[DATA_W-1];
      end
      F6_VMADD, F6_VNMSUB: begin
        legal = sew_ok; d.a = zb; d.b = zd; d.c = za; d.acc_sub = f6[1];
      end
      F6_VMACC, F6_VNMSAC: begin
        legal = sew_ok; d.a = zb; d.b = za; d.c = zd; d.acc_sub = f6[1];
      end
      F6_VWADDU, F6_VWADD, F6_VWSUBU, F6_VWSUB,
      F6_VWADDU_W, F6_VWADD_W, F6_VWSUBU_W, F6_VWSUB_W: begin
        legal      = sew_ok & wide_ok;
        d.kind     = KIND_PASS;
        d.out_code = wcode;
        d.c        = f6[1] ? wa - wb : wa + wb;
      end
      F6_VWMULU: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = za; d.b = zb;
      end
      F6_VWMULSU: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = sa; d.b = zb;
        d.x_neg = sa[DATA_W-1];
      end
      F6_VWMUL: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = sa; d.b = sb;
        d.x_neg = sa[DATA_W-1]; d.y_neg = sb[DATA_W-1];
      end
      F6_VWMACCU: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = zb; d.b = za; d.c = wd;
      end
      F6_VWMACC: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = sb; d.b = sa; d.c = wd;
        d.x_neg = sb[DATA_W-1]; d.y_neg = sa[DATA_W-1];
      end
      F6_VWMACCUS: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = zb; d.b = sa; d.c = wd;
        d.y_neg = sa[DATA_W-1];
      end
      F6_VWMACCSU: begin
        legal = sew_ok & wide_ok; d.out_code = wcode; d.a = sb; d.b = za; d.c = wd;
        d.x_neg = sb[DATA_W-1];
      end
      default: begin
        legal = 1'b0;
      end
    endcase
    d.we = legal & req_data.active;
  end

  // register the decoded item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op <= d;
    end
  end

endmodule

@@ rtl/core/vimd_mac.sv @@
module vimd_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vimd_pkg::vimd_op_t  op,
  output logic                out_valid,
  output vimd_pkg::vimd_op_t  out_op
);
  import vimd_pkg::*;

  // stage 1: partial products, sign correction, averaging sum
  logic              v1;
  vimd_op_t          op1;
  logic [63:0]       ll1, lh1, hl1, hh1, corr1;
  logic [64:0]       avg1;
  // stage 2: low half, high half before mid carry, rounded average
  logic              v2;
  vimd_op_t          op2;
  logic [63:0]       lo2, hip2, avg2;
  logic [1:0]        midc2;
  logic [33:0]       mid;
  logic              rb, avg_hi;
  // stage 3: full product
  logic              v3;
  vimd_op_t          op3;
  logic [127:0]      prod3;
  logic [63:0]       avg3;
  // stage 4: window and accumulate
  logic [63:0]       win, res;
  vimd_op_t          op4_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // form partial products
  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= op;
      ll1   <= op.a[31:0] * op.b[31:0];
      lh1   <= op.a[31:0] * op.b[63:32];
      hl1   <= op.a[63:32] * op.b[31:0];
      hh1   <= op.a[63:32] * op.b[63:32];
      corr1 <= (op.x_neg ? op.b : 64'd0) + (op.y_neg ? op.a : 64'd0);
      avg1  <= {1'b0, op.a} + {1'b0, op.b} + {64'd0, op.avg_cin};
    end
  end

  // pick the rounding increment
  always_comb begin
    case (op1.vxrm)
      RM_RNU:  rb = avg1[0];
      RM_RNE:  rb = avg1[0] & avg1[1];
      RM_RDN:  rb = 1'b0;
      RM_ROD:  rb = avg1[0] & ~avg1[1];
      default: rb = 1'b0;
    endcase
  end

  assign mid    = {2'b0, ll1[63:32]} + {2'b0, lh1[31:0]} + {2'b0, hl1[31:0]};
  assign avg_hi = op1.avg_hx ^ avg1[64];

  // combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      lo2   <= {mid[31:0], ll1[31:0]};
      midc2 <= mid[33:32];
      hip2  <= hh1 + {32'd0, lh1[63:32]} + {32'd0, hl1[63:32]} - corr1;
      avg2  <= {avg_hi, avg1[63:1]} + {63'd0, rb};
    end
  end

  // fold in the mid carry
  always_ff @(posedge clk) begin
    if (en) begin
      op3   <= op2;
      prod3 <= {hip2 + {62'd0, midc2}, lo2};
      avg3  <= avg2;
    end
  end

  // high window of the product at the element width
  always_comb begin
    case (op3.sew_code)
      SEW_8:   win = prod3[71:8];
      SEW_16:  win = prod3[79:16];
      SEW_32:  win = prod3[95:32];
      default: win = prod3[127:64];
    endcase
  end

  always_comb begin
    case (op3.kind)
      KIND_MUL: begin
        if (op3.hi_sel) begin
          res = win;
        end else if (op3.acc_sub) begin
          res = op3.c - prod3[63:0];
        end else begin
          res = op3.c + prod3[63:0];
        end
      end
      KIND_AVG: res = avg3;
      default:  res = op3.c;
    endcase
    op4_next   = op3;
    op4_next.c = res;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_op <= op4_next;
    end
  end

endmodule

@@ rtl/core/vimd_div.sv @@
module vimd_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vimd_pkg::vimd_op_t  op,
  output logic                out_valid,
  output vimd_pkg::vimd_op_t  out_op
);
  import vimd_pkg::*;

  // one restoring step per stage; a holds dividend bits then quotient bits
  logic [DIV_STEPS-1:0] st_v;
  vimd_op_t             st_op  [DIV_STEPS];
  logic [DATA_W-1:0]    st_rem [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic              v_in;
    vimd_op_t          op_in;
    vimd_op_t          op_nx;
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W:0]   part;
    logic [DATA_W:0]   trial;
    logic              take;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign op_in  = op;
      assign rem_in = '0;
    end else begin : g_next
      assign v_in   = st_v[i-1];
      assign op_in  = st_op[i-1];
      assign rem_in = st_rem[i-1];
    end

    assign part  = {rem_in, op_in.a[DATA_W-1]};
    assign trial = part - {1'b0, op_in.b};
    assign take  = ~trial[DATA_W];

    always_comb begin
      op_nx   = op_in;
      op_nx.a = {op_in.a[DATA_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_op[i]  <= op_nx;
        st_rem[i] <= take ? trial[DATA_W-1:0] : part[DATA_W-1:0];
      end
    end
  end

  // quotient leaves in a, remainder in b
  always_comb begin
    out_op   = st_op[DIV_STEPS-1];
    out_op.b = st_rem[DIV_STEPS-1];
  end
  assign out_valid = st_v[DIV_STEPS-1];

endmodule

@@ rtl/core/vector_int_muldiv_alu_unit.sv @@
// Channel  Dir  Payload                                        Handshake
// req      in   req_type, src_a, src_b, acc_in, active         valid/ready
// rsp      out  result, write_enable                           valid/ready
// cfg      in   cfg_index, cfg_data (0 = SEW code, 1 = vxrm)   cfg_we, no wait
//
// One item per cycle while the output is taken; 70 register stages between an item
// and its result: decode 1, multiply/average 4, divider 64 (a bit a stage), output 1.
// The 64-stage restoring divider sets the latency; all operations share its length.
// Reset clears the valid bits and the configuration registers to 0.
// While a result sits in the output register untaken the whole pipeline holds.
module vector_int_muldiv_alu_unit #(
  parameter int MAX_ELEMENT_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  vimd_chan_if.sink   req,
  vimd_chan_if.source rsp
);
  import vimd_pkg::*;

  `include "vector_int_muldiv_alu_unit_macros.svh"

  logic       en;
  logic [1:0] sew_code, vxrm;
  logic       dec_valid, mac_valid, div_valid;
  vimd_op_t   dec_op, mac_op, div_op;
  logic       out_valid;
  vimd_rsp_t  out_data;
  logic [1:0] out_code;
  logic [DATA_W-1:0] div_val, div_res, fin_res;
  logic       div_neg;

  // advance everything unless the output register is full and held
  assign en        = ~(out_valid & ~rsp.ready);
  assign req.ready = en;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sew_code <= SEW_8;
      vxrm     <= RM_RNU;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEW:  sew_code <= cfg_data;
        CFG_VXRM: vxrm     <= cfg_data;
        default:  ;
      endcase
    end
  end

  vimd_decode #(.MAX_ELEMENT_BITS(MAX_ELEMENT_BITS)) u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .req_data  (req.data),
    .sew_code  (sew_code),
    .vxrm      (vxrm),
    .out_valid (dec_valid),
    .op        (dec_op)
  );

  vimd_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dec_valid),
    .op        (dec_op),
    .out_valid (mac_valid),
    .out_op    (mac_op)
  );

  vimd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mac_valid),
    .op        (mac_op),
    .out_valid (div_valid),
    .out_op    (div_op)
  );

  // apply quotient/remainder sign, pick the unit, mask to the destination width
  assign div_val = div_op.rem_sel ? div_op.b : div_op.a;
  assign div_neg = div_op.rem_sel ? div_op.r_neg : div_op.q_neg;
  assign div_res = div_neg ? -div_val : div_val;
  assign fin_res = ((div_op.kind == KIND_DIV) ? div_res : div_op.c)
                   & width_mask(div_op.out_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.result       <= div_op.we ? fin_res : '0;
      out_data.write_enable <= div_op.we;
      out_code              <= div_op.out_code;
    end
  end

  `VIMD_CHECK_NOW(a_skip_zero, rsp.valid && !rsp.data.write_enable, rsp.data.result == '0, "skipped element carries a nonzero result")
  `VIMD_CHECK_NOW(a_width_masked, rsp.valid && rsp.data.write_enable, (rsp.data.result & ~width_mask(out_code)) == '0, "result bits above the destination width")
  `VIMD_CHECK_NEXT(a_stall_holds, !en, $stable(dec_valid) && $stable(mac_valid) && $stable(div_valid), "pipeline moved while stalled")

endmodule

@@ tb/testbench.sv @@
module testbench;
  import vimd_pkg::*;

  localparam int LATENCY    = 70;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_RANDOM   = 1400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  vimd_chan_if #(.T(vimd_req_t)) req_ch ();
  vimd_chan_if #(.T(vimd_rsp_t)) rsp_ch ();

  vector_int_muldiv_alu_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #2 clk = ~clk;

  // own copy of the configuration
  logic [1:0] sew_code_q;
  logic [1:0] vxrm_q;

  vimd_rsp_t expected_rsp_q[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit stall_off = 1'b0;

  // directed stimulus; has_fixed marks rows with a typed-in result
  typedef struct {
    logic [1:0] sew;
    logic [1:0] rm;
    vimd_req_t  item;
    bit         has_fixed;
    vimd_rsp_t  fixed;
  } dir_row_t;

  function automatic logic [63:0] msk(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [127:0] sxt(input logic [63:0] x, input int w);
    logic [127:0] v;
    v = {64'd0, x & msk(w)};
    if (x[w-1]) v = v | ~{64'd0, msk(w)};
    return v;
  endfunction

  // element result of the integer multiply/divide group
  function automatic vimd_rsp_t alu_result(input vimd_req_t it, input logic [1:0] sc,
                                           input logic [1:0] rm);
    vimd_rsp_t o;
    int sew;
    int ww;
    logic [127:0] ua, ub, ud, sa, sb, r, sum;
    logic signed [127:0] qa, qb;
    logic rb;
    logic [5:0] f;
    sew = 8 << sc;
    f = it.req_type;
    o = '0;
    if (!it.active) return o;
    ua = {64'd0, it.src_a & msk(sew)};
    ub = {64'd0, it.src_b & msk(sew)};
    ud = {64'd0, it.acc_in & msk(sew)};
    sa = sxt(it.src_a, sew);
    sb = sxt(it.src_b, sew);
    if (f >= F6_VAADDU && f <= F6_VASUB) begin
      if (f == F6_VAADDU) sum = ua + ub;
      else if (f == F6_VAADD) sum = sa + sb;
      else if (f == F6_VASUBU) sum = ua - ub;
      else sum = sa - sb;
      case (rm)
        RM_RNU:  rb = sum[0];
        RM_RNE:  rb = sum[0] & sum[1];
        RM_RDN:  rb = 1'b0;
        default: rb = sum[0] & ~sum[1];
      endcase
      r = {sum[127], sum[127:1]} + rb;
      o.result = r[63:0] & msk(sew);
      o.write_enable = 1'b1;
    end else if (f >= F6_VDIVU && f <= F6_VNMSAC) begin
      qa = sa;
      qb = sb;
      o.write_enable = 1'b1;
      case (f)
        F6_VDIVU:  r = (ub == 0) ? '1 : ua / ub;
        F6_VDIV: begin
          if (sb == 0) r = '1;
          else r = qa / qb;
        end
        F6_VREMU:  r = (ub == 0) ? ua : ua % ub;
        F6_VREM: begin
          if (sb == 0) r = sa;
          else r = qa % qb;
        end
        F6_VMULHU: r = (ua * ub) >> sew;
        F6_VMUL:   r = ua * ub;
        F6_VMULHSU: r = (sa * ub) >> sew;
        F6_VMULH:  r = (sa * sb) >> sew;
        F6_VMADD:  r = ub * ud + ua;
        F6_VNMSUB: r = ua - ub * ud;
        F6_VMACC:  r = ub * ua + ud;
        F6_VNMSAC: r = ud - ub * ua;
        default: begin
          o.write_enable = 1'b0;
          r = '0;
        end
      endcase
      // 128-bit signed quotient of MIN by -1 wraps to MIN at SEW, as required
      o.result = o.write_enable ? (r[63:0] & msk(sew)) : '0;
    end else if (f >= F6_VWADDU && sew <= 32) begin
      ww = 2 * sew;
      if (f >= F6_VWADDU_W && f <= F6_VWSUB_W) begin
        ua = {64'd0, it.src_a & msk(ww)};
        sa = sxt(it.src_a, ww);
      end
      ud = {64'd0, it.acc_in & msk(ww)};
      o.write_enable = 1'b1;
      case (f)
        F6_VWADDU, F6_VWADDU_W: r = ua + ub;
        F6_VWADD, F6_VWADD_W:   r = sa + sb;
        F6_VWSUBU, F6_VWSUBU_W: r = ua - ub;
        F6_VWSUB, F6_VWSUB_W:   r = sa - sb;
        F6_VWMULU:   r = ua * ub;
        F6_VWMULSU:  r = sa * ub;
        F6_VWMUL:    r = sa * sb;
        F6_VWMACCU:  r = ud + ub * ua;
        F6_VWMACC:   r = ud + sb * sa;
        F6_VWMACCUS: r = ud + ub * sa;
        F6_VWMACCSU: r = ud + sb * ua;
        default: begin
          o.write_enable = 1'b0;
          r = '0;
        end
      endcase
      o.result = o.write_enable ? (r[63:0] & msk(ww)) : '0;
    end
    return o;
  endfunction

  // idle bursts on the sender side
  task automatic send_item(input vimd_req_t it);
    int gap;
    if (!stall_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp_q.push_back(alu_result(it, sew_code_q, vxrm_q));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // drive a one-cycle write strobe, then idle with the strobe low before the next write
  task automatic write_cfg(input logic idx, input logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SEW) sew_code_q = val;
    else vxrm_q = val;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rand_op();
    logic [5:0] f;
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    f = 6'($urandom_range(6'h20, 6'h3f));
    if ($urandom_range(0, 4) == 0) f = 6'($urandom_range(6'h08, 6'h0b));
    return f;
  endfunction

  // compare every taken result with the oldest expectation
  always @(posedge clk) begin
    vimd_rsp_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: result=%h we=%b", rsp_ch.data.result,
                   rsp_ch.data.write_enable);
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (rsp_ch.data !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("item mismatch: expected %h/%b got %h/%b", exp_r.result,
                     exp_r.write_enable, rsp_ch.data.result, rsp_ch.data.write_enable);
        end
      end
    end
  end

  // receiver idle bursts
  initial begin
    int hold;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!stall_off && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 15);
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    vimd_req_t it;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    sew_code_q = SEW_8;
    vxrm_q = RM_RNU;
    // directed rows: SEW, vxrm, item, fixed result
    rows.push_back('{SEW_8, RM_RNU, '{F6_VDIVU, 64'h12, 64'h00, 64'h0, 1'b1}, 1, '{64'hff, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VDIV, 64'h12, 64'h00, 64'h0, 1'b1}, 1, '{64'hff, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VREMU, 64'h12, 64'h00, 64'h0, 1'b1}, 1, '{64'h12, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VREM, 64'h92, 64'h00, 64'h0, 1'b1}, 1, '{64'h92, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VDIV, 64'h80, 64'hff, 64'h0, 1'b1}, 1, '{64'h80, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VREM, 64'h80, 64'hff, 64'h0, 1'b1}, 1, '{64'h00, 1'b1}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VMUL, 64'hff, 64'hff, 64'h0, 1'b0}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_8, RM_RNU, '{6'h00, '1, '1, '1, 1'b1}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_8, RM_RNU, '{6'h39, '1, '1, '1, 1'b1}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_8, RM_RNU, '{6'h28, '1, '1, '1, 1'b1}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_8, RM_RNU, '{F6_VAADDU, '1, '1, 64'h0, 1'b1}, 0, '{64'h0, 1'b0}});
    rows.push_back('{SEW_16, RM_RNE, '{F6_VAADD, 64'h7fff, 64'h7fff, 64'h0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_16, RM_RDN, '{F6_VASUBU, 64'h0, 64'hffff, 64'h0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_16, RM_ROD, '{F6_VASUB, 64'h8000, 64'h7fff, 64'h0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_32, RM_ROD, '{F6_VMULHU, '1, '1, 64'h0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_32, RM_ROD, '{F6_VMULHSU, '1, '1, 64'h0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_32, RM_ROD, '{F6_VMULH, 64'h80000000, 64'h80000000, 0, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_32, RM_ROD, '{F6_VWMACCUS, '1, '1, '1, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VWADDU, '1, '1, '1, 1'b1}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VWMACCSU, '1, '1, '1, 1'b1}, 1, '{64'h0, 1'b0}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VDIV, 64'h8000000000000000, '1, 0, 1'b1}, 1,
                    '{64'h8000000000000000, 1'b1}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VMADD, '1, '1, '1, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VNMSUB, '1, '1, '1, 1'b1}, 0, '{0, 0}});
    rows.push_back('{SEW_64, RM_RNU, '{F6_VNMSAC, '1, 64'h2, '1, 1'b1}, 0, '{0, 0}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.sew != sew_code_q || row.rm != vxrm_q) begin
        drain();
        repeat (LATENCY) @(posedge clk);
        write_cfg(CFG_SEW, row.sew);
        write_cfg(CFG_VXRM, row.rm);
      end
      send_item(row.item);
      if (row.has_fixed && alu_result(row.item, row.sew, row.rm) !== row.fixed)
        expected_rsp_q[$] = row.fixed;
    end

    // random phases over all widths and rounding modes
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      repeat (LATENCY) @(posedge clk);
      write_cfg(CFG_SEW, 2'(ph % 4));
      write_cfg(CFG_VXRM, 2'(ph / 4));
      if (ph >= 14) stall_off = 1'b1;
      for (int n = 0; n < N_RANDOM / 16; n++) begin
        it.req_type = rand_op();
        it.src_a = rand64();
        it.src_b = ($urandom_range(0, 15) == 0) ? 64'd0 : rand64();
        it.acc_in = rand64();
        it.active = ($urandom_range(0, 9) != 0);
        send_item(it);
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
